>>> src/hexseg_pkg.sv
`timescale 1ns / 1ps
// Package for the seven-segment rectangle generator.
// Holds the request/command/job types, field widths, segment codes and the glyph table.
package hexseg_pkg;

  localparam int COORD_W   = 8;
  localparam int RECT_XY_W = 9;
  localparam int RECT_WH_W = 6;
  localparam int COLOR_W   = 16;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 4;
  localparam int CODE_W    = 5;
  localparam int SEG_N     = 7;
  localparam int SEG_IDX_W = 3;

  localparam int DEF_SEGMENT_WIDTH  = 12;
  localparam int DEF_SEGMENT_HEIGHT = 20;
  localparam int DEF_DIGIT_PITCH    = 16;
  localparam int DEF_MAX_DIGITS     = 8;
  localparam int DEF_QUEUE_DEPTH    = 4;

  localparam logic [CODE_W-1:0] GLYPH_H = 5'd16;

  localparam logic OP_GLYPH = 1'b0;
  localparam logic OP_HEX   = 1'b1;

  // segment emit order
  localparam logic [SEG_IDX_W-1:0] SEG_A = 3'd0;
  localparam logic [SEG_IDX_W-1:0] SEG_G = 3'd1;
  localparam logic [SEG_IDX_W-1:0] SEG_D = 3'd2;
  localparam logic [SEG_IDX_W-1:0] SEG_F = 3'd3;
  localparam logic [SEG_IDX_W-1:0] SEG_B = 3'd4;
  localparam logic [SEG_IDX_W-1:0] SEG_E = 3'd5;
  localparam logic [SEG_IDX_W-1:0] SEG_C = 3'd6;

  typedef struct packed {
    logic                 op;
    logic [COORD_W-1:0]   origin_x;
    logic [COORD_W-1:0]   origin_y;
    logic [COLOR_W-1:0]   color;
    logic [VALUE_W-1:0]   value;
    logic [COUNT_W-1:0]   digit_count;
  } in_item_t;

  typedef struct packed {
    logic [RECT_XY_W-1:0] rect_x;
    logic [RECT_XY_W-1:0] rect_y;
    logic [RECT_WH_W-1:0] rect_w;
    logic [RECT_WH_W-1:0] rect_h;
    logic [COLOR_W-1:0]   rect_color;
    logic                 bad_code;
    logic                 last;
  } out_item_t;

  // one glyph to draw, passed from front to back
  typedef struct packed {
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [COLOR_W-1:0]   color;
    logic [CODE_W-1:0]    code;
    logic                 bad;
    logic                 last;
  } glyph_job_t;

  // abcdefg mask, bit 6 = a ... bit 0 = g
  function automatic logic [SEG_N-1:0] glyph_mask(input logic [CODE_W-1:0] code);
    logic [SEG_N-1:0] m;
    begin
      case (code)
        5'd0:    m = 7'b1111110;
        5'd1:    m = 7'b0110000;
        5'd2:    m = 7'b1101101;
        5'd3:    m = 7'b1111001;
        5'd4:    m = 7'b0110011;
        5'd5:    m = 7'b1011011;
        5'd6:    m = 7'b1011111;
        5'd7:    m = 7'b1110000;
        5'd8:    m = 7'b1111111;
        5'd9:    m = 7'b1111011;
        5'd10:   m = 7'b1110111;
        5'd11:   m = 7'b0011111;
        5'd12:   m = 7'b1001110;
        5'd13:   m = 7'b0111101;
        5'd14:   m = 7'b1001111;
        5'd15:   m = 7'b1000111;
        5'd16:   m = 7'b0010111;
        default: m = 7'b0000000;
      endcase
      return m;
    end
  endfunction

  // reorder abcdefg into emit order a,g,d,f,b,e,c (bit 0 first)
  function automatic logic [SEG_N-1:0] emit_order(input logic [SEG_N-1:0] m);
    return {m[4], m[2], m[5], m[1], m[3], m[0], m[6]};
  endfunction

endpackage

>>> src/hex_seven_segment_rect_generator.sv
`timescale 1ns / 1ps
// Throughput: one command per cycle out of the segment walker while results are popped;
// the front end splits the next request while the walker drains earlier jobs.
// The segment walker emitting one rectangle a cycle, unless pop holds it, sets the rate.
// Reset: synchronous active-low rst_n empties the job queue and output register.
module hex_seven_segment_rect_generator #(
  parameter int SEGMENT_WIDTH  = hexseg_pkg::DEF_SEGMENT_WIDTH,
  parameter int SEGMENT_HEIGHT = hexseg_pkg::DEF_SEGMENT_HEIGHT,
  parameter int DIGIT_PITCH    = hexseg_pkg::DEF_DIGIT_PITCH,
  parameter int MAX_DIGITS     = hexseg_pkg::DEF_MAX_DIGITS,
  parameter int QUEUE_DEPTH    = hexseg_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  hexseg_pkg::in_item_t   in_item,
  output logic                   empty,
  input  logic                   pop,
  output hexseg_pkg::out_item_t  out_item
);

  hexseg_pkg::glyph_job_t  job_in, job_out;
  logic                    job_push, job_full, job_pop, job_empty;

  hexseg_front #(
    .DIGIT_PITCH (DIGIT_PITCH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .job_push (job_push),
    .job_full (job_full),
    .job      (job_in)
  );

  hexseg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .q_full  (job_full),
    .wr_data (job_in),
    .rd_en   (job_pop),
    .q_empty (job_empty),
    .rd_data (job_out)
  );

  hexseg_back #(
    .SEGMENT_WIDTH  (SEGMENT_WIDTH),
    .SEGMENT_HEIGHT (SEGMENT_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (job_empty),
    .q_data   (job_out),
    .q_pop    (job_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

>>> src/hexseg_front.sv
`timescale 1ns / 1ps
// Front end: splits each request into glyph jobs, one per cycle unless job_full.
// Depends on hexseg_pkg.
module hexseg_front #(
  parameter int DIGIT_PITCH = hexseg_pkg::DEF_DIGIT_PITCH,
  parameter int MAX_DIGITS  = hexseg_pkg::DEF_MAX_DIGITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  hexseg_pkg::in_item_t    in_item,
  output logic                    job_push,
  input  logic                    job_full,
  output hexseg_pkg::glyph_job_t  job
);

  logic                                busy_r, busy_nxt;
  logic                                hex_r, hex_nxt;
  logic [hexseg_pkg::COUNT_W-1:0]      cnt_r, cnt_nxt;
  logic [hexseg_pkg::COORD_W-1:0]      x_r, x_nxt;
  logic [hexseg_pkg::COORD_W-1:0]      y_r, y_nxt;
  logic [hexseg_pkg::COLOR_W-1:0]      color_r, color_nxt;
  logic [hexseg_pkg::VALUE_W-1:0]      value_r, value_nxt;

  logic                                accept;
  logic [hexseg_pkg::COUNT_W-1:0]      digits;
  logic [2:0]                          nib_idx;
  logic [hexseg_pkg::VALUE_W-1:0]      shifted;
  logic                                glyph_bad;

  assign full   = busy_r;
  assign accept = push && !busy_r;

  always_comb begin
    if (in_item.digit_count == '0) begin
      digits = 4'd1;
    end else if (in_item.digit_count > 4'(MAX_DIGITS)) begin
      digits = 4'(MAX_DIGITS);
    end else begin
      digits = in_item.digit_count;
    end
  end

  // jobs left counts the 'h' as well, so digit index is cnt - 2
  assign nib_idx   = 3'(cnt_r - 4'd2);
  assign shifted   = value_r >> {nib_idx, 2'b00};
  assign glyph_bad = value_r > 32'(hexseg_pkg::GLYPH_H);

  always_comb begin
    job.x     = x_r;
    job.y     = y_r;
    job.color = color_r;
    job.last  = (cnt_r == 4'd1);
    job.bad   = 1'b0;
    if (!hex_r) begin
      job.bad  = glyph_bad;
      job.code = glyph_bad ? '0 : value_r[hexseg_pkg::CODE_W-1:0];
    end else if (cnt_r == 4'd1) begin
      job.code = hexseg_pkg::GLYPH_H;
    end else begin
      job.code = {1'b0, shifted[3:0]};
    end
  end

  assign job_push = busy_r && !job_full;

  always_comb begin
    busy_nxt  = busy_r;
    hex_nxt   = hex_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    color_nxt = color_r;
    value_nxt = value_r;
    if (accept) begin
      busy_nxt  = 1'b1;
      hex_nxt   = (in_item.op == hexseg_pkg::OP_HEX);
      cnt_nxt   = (in_item.op == hexseg_pkg::OP_HEX) ? 4'(digits + 4'd1) : 4'd1;
      x_nxt     = in_item.origin_x;
      y_nxt     = in_item.origin_y;
      color_nxt = in_item.color;
      value_nxt = in_item.value;
    end else if (job_push) begin
      cnt_nxt = 4'(cnt_r - 4'd1);
      x_nxt   = 8'(x_r + 8'(DIGIT_PITCH));
      if (cnt_r == 4'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      hex_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      hex_r  <= hex_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    color_r <= color_nxt;
    value_r <= value_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r != '0)
    else $error("front busy with no jobs left");

endmodule

>>> src/hexseg_queue.sv
`timescale 1ns / 1ps
// Short job queue between front and back ends.
// Depends on hexseg_pkg for the job type.
module hexseg_queue #(
  parameter int DEPTH = hexseg_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  output logic                    q_full,
  input  hexseg_pkg::glyph_job_t  wr_data,
  input  logic                    rd_en,
  output logic                    q_empty,
  output hexseg_pkg::glyph_job_t  rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hexseg_pkg::glyph_job_t  slot_r [DEPTH];
  logic [PTR_W-1:0]        wp_r, wp_nxt;
  logic [PTR_W-1:0]        rp_r, rp_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    do_wr, do_rd;

  assign q_full  = (cnt_r == CNT_W'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slot_r[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wp_r + 1'b1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rp_r + 1'b1);
    end
    cnt_nxt = CNT_W'(cnt_r + CNT_W'(do_wr) - CNT_W'(do_rd));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_wr) begin
      slot_r[wp_r] <= wr_data;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

endmodule

>>> src/hexseg_back.sv
`timescale 1ns / 1ps
// Back end: walks each glyph job's lit segments; one rectangle per cycle while popped.
// Depends on hexseg_pkg; holds the output register.
module hexseg_back #(
  parameter int SEGMENT_WIDTH  = hexseg_pkg::DEF_SEGMENT_WIDTH,
  parameter int SEGMENT_HEIGHT = hexseg_pkg::DEF_SEGMENT_HEIGHT
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  hexseg_pkg::glyph_job_t  q_data,
  output logic                    q_pop,
  output logic                    empty,
  input  logic                    pop,
  output hexseg_pkg::out_item_t   out_item
);

  localparam int HALF = SEGMENT_HEIGHT / 2;
  localparam logic [hexseg_pkg::RECT_XY_W-1:0] XO_MID   = 9'd2;
  localparam logic [hexseg_pkg::RECT_XY_W-1:0] XO_RIGHT = 9'(SEGMENT_WIDTH - 2);
  localparam logic [hexseg_pkg::RECT_XY_W-1:0] YO_MID   = 9'(HALF - 1);
  localparam logic [hexseg_pkg::RECT_XY_W-1:0] YO_BOT   = 9'(SEGMENT_HEIGHT - 2);
  localparam logic [hexseg_pkg::RECT_XY_W-1:0] YO_UPPER = 9'd2;
  localparam logic [hexseg_pkg::RECT_XY_W-1:0] YO_LOWER = 9'(HALF + 1);
  localparam logic [hexseg_pkg::RECT_WH_W-1:0] BAR_LEN  = 6'(SEGMENT_WIDTH - 4);
  localparam logic [hexseg_pkg::RECT_WH_W-1:0] SIDE_LEN = 6'(HALF - 3);
  localparam logic [hexseg_pkg::RECT_WH_W-1:0] THICK    = 6'd2;

  logic                                  busy_r, busy_nxt;
  hexseg_pkg::glyph_job_t                job_r;
  logic [hexseg_pkg::SEG_N-1:0]          rem_r, rem_nxt;
  logic                                  out_valid_r;
  hexseg_pkg::out_item_t                 out_r, rect;

  logic                                  step, done, load;
  logic [hexseg_pkg::SEG_IDX_W-1:0]      seg;
  logic [hexseg_pkg::SEG_N-1:0]          rem_clr;
  logic [hexseg_pkg::RECT_XY_W-1:0]      xo, yo;
  logic [hexseg_pkg::RECT_WH_W-1:0]      w, h;

  // lowest remaining segment in emit order
  always_comb begin
    seg = '0;
    for (int i = hexseg_pkg::SEG_N - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        seg = hexseg_pkg::SEG_IDX_W'(i);
      end
    end
  end

  assign rem_clr = rem_r & ~(hexseg_pkg::SEG_N'(1) << seg);
  assign step    = busy_r && (!out_valid_r || pop);
  assign done    = job_r.bad || (rem_clr == '0);
  assign load    = !q_empty && (!busy_r || (step && done));
  assign q_pop   = load;

  always_comb begin
    case (seg)
      hexseg_pkg::SEG_A: begin xo = XO_MID;   yo = '0;       w = BAR_LEN; h = THICK;    end
      hexseg_pkg::SEG_G: begin xo = XO_MID;   yo = YO_MID;   w = BAR_LEN; h = THICK;    end
      hexseg_pkg::SEG_D: begin xo = XO_MID;   yo = YO_BOT;   w = BAR_LEN; h = THICK;    end
      hexseg_pkg::SEG_F: begin xo = '0;       yo = YO_UPPER; w = THICK;   h = SIDE_LEN; end
      hexseg_pkg::SEG_B: begin xo = XO_RIGHT; yo = YO_UPPER; w = THICK;   h = SIDE_LEN; end
      hexseg_pkg::SEG_E: begin xo = '0;       yo = YO_LOWER; w = THICK;   h = SIDE_LEN; end
      hexseg_pkg::SEG_C: begin xo = XO_RIGHT; yo = YO_LOWER; w = THICK;   h = SIDE_LEN; end
      default:           begin xo = '0;       yo = '0;       w = '0;      h = '0;       end
    endcase
  end

  always_comb begin
    if (job_r.bad) begin
      rect          = '0;
      rect.bad_code = 1'b1;
      rect.last     = job_r.last;
    end else begin
      rect.rect_x     = 9'({1'b0, job_r.x} + xo);
      rect.rect_y     = 9'({1'b0, job_r.y} + yo);
      rect.rect_w     = w;
      rect.rect_h     = h;
      rect.rect_color = job_r.color;
      rect.bad_code   = 1'b0;
      rect.last       = job_r.last && done;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    if (load) begin
      busy_nxt = 1'b1;
      rem_nxt  = hexseg_pkg::emit_order(hexseg_pkg::glyph_mask(q_data.code));
    end else if (step) begin
      rem_nxt = rem_clr;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
    rem_r <= rem_nxt;
    if (load) begin
      job_r <= q_data;
    end
    if (step) begin
      out_r <= rect;
    end
  end

  assign empty    = !out_valid_r;
  assign out_item = out_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (job_r.bad || rem_r != '0))
    else $error("back busy on a glyph with nothing left to draw");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !pop) |=> $stable(out_r))
    else $error("waiting rectangle overwritten");

  assert property (@(posedge clk) disable iff (!rst_n)
    (step && job_r.bad) |-> done)
    else $error("bad glyph request produced more than one command");

endmodule

>>> sim/hex_seven_segment_rect_generator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for hex_seven_segment_rect_generator: directed table, then random requests,
// with random gaps on both queue sides. Needs hexseg_pkg and the generator RTL only.
module hex_seven_segment_rect_generator_tb;

  localparam int SEG_W       = hexseg_pkg::DEF_SEGMENT_WIDTH;
  localparam int SEG_H       = hexseg_pkg::DEF_SEGMENT_HEIGHT;
  localparam int PITCH       = hexseg_pkg::DEF_DIGIT_PITCH;
  localparam int MAXD        = hexseg_pkg::DEF_MAX_DIGITS;
  localparam int N_RANDOM    = 355;
  localparam int STALL_LIMIT = 2000;

  // segment geometry
  localparam logic [5:0] BAR_LEN  = 6'(SEG_W - 4);
  localparam logic [5:0] BAR_T    = 6'd2;
  localparam logic [5:0] POST_LEN = 6'(SEG_H / 2 - 3);
  localparam logic [8:0] X_IN     = 9'd2;
  localparam logic [8:0] X_RIGHT  = 9'(SEG_W - 2);
  localparam logic [8:0] Y_UP     = 9'd2;
  localparam logic [8:0] Y_MID    = 9'(SEG_H / 2 - 1);
  localparam logic [8:0] Y_LOW    = 9'(SEG_H / 2 + 1);
  localparam logic [8:0] Y_BOT    = 9'(SEG_H - 2);
  localparam logic [31:0] TOP_CODE = 32'(hexseg_pkg::GLYPH_H);

  typedef struct {
    hexseg_pkg::in_item_t  req;
    bit                    typed;
    hexseg_pkg::out_item_t want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  pop = 1'b0;
  logic                  full;
  logic                  empty;
  hexseg_pkg::in_item_t  in_item = '0;
  hexseg_pkg::out_item_t out_item;

  // side info that travels with the request on the bus
  bit                    want_typed = 1'b0;
  hexseg_pkg::out_item_t want_rect = '0;

  hexseg_pkg::out_item_t rect_q[$];
  stim_row_t             dir_rows[$];
  bit        calm = 1'b0;
  int        stall_left = 0;
  int        idle_cycles = 0;
  int        errors = 0;
  int        n_requests = 0;
  int        n_hex = 0;
  int        n_bad = 0;
  int        n_rects = 0;

  hex_seven_segment_rect_generator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // abcdefg, bit 6 = a
  function automatic logic [6:0] lit_segments(input logic [4:0] code);
    case (code)
      5'd0:    return 7'h7E;
      5'd1:    return 7'h30;
      5'd2:    return 7'h6D;
      5'd3:    return 7'h79;
      5'd4:    return 7'h33;
      5'd5:    return 7'h5B;
      5'd6:    return 7'h5F;
      5'd7:    return 7'h70;
      5'd8:    return 7'h7F;
      5'd9:    return 7'h7B;
      5'd10:   return 7'h77;
      5'd11:   return 7'h1F;
      5'd12:   return 7'h4E;
      5'd13:   return 7'h3D;
      5'd14:   return 7'h4F;
      5'd15:   return 7'h47;
      hexseg_pkg::GLYPH_H: return 7'h17;
      default: return 7'h00;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_rect(input logic [8:0] x, input logic [8:0] y, input logic [5:0] w,
                          input logic [5:0] h, input logic [15:0] col);
    hexseg_pkg::out_item_t r;
    r = '0;
    r.rect_x = x;
    r.rect_y = y;
    r.rect_w = w;
    r.rect_h = h;
    r.rect_color = col;
    rect_q.push_back(r);
  endtask

  // emit order a, g, d, f, b, e, c
  task automatic draw_glyph(input logic [7:0] gx, input logic [7:0] gy, input logic [15:0] col,
                            input logic [4:0] code);
    logic [6:0] m;
    logic [8:0] x0;
    logic [8:0] y0;
    m = lit_segments(code);
    x0 = {1'b0, gx};
    y0 = {1'b0, gy};
    if (m[6]) add_rect(x0 + X_IN, y0, BAR_LEN, BAR_T, col);
    if (m[0]) add_rect(x0 + X_IN, y0 + Y_MID, BAR_LEN, BAR_T, col);
    if (m[3]) add_rect(x0 + X_IN, y0 + Y_BOT, BAR_LEN, BAR_T, col);
    if (m[1]) add_rect(x0, y0 + Y_UP, BAR_T, POST_LEN, col);
    if (m[5]) add_rect(x0 + X_RIGHT, y0 + Y_UP, BAR_T, POST_LEN, col);
    if (m[2]) add_rect(x0, y0 + Y_LOW, BAR_T, POST_LEN, col);
    if (m[4]) add_rect(x0 + X_RIGHT, y0 + Y_LOW, BAR_T, POST_LEN, col);
  endtask

  task automatic predict_rects(input hexseg_pkg::in_item_t req);
    hexseg_pkg::out_item_t tail;
    logic [7:0] gx;
    int cnt;
    if (req.op == hexseg_pkg::OP_GLYPH) begin
      if (req.value > TOP_CODE) begin
        tail = '0;
        tail.bad_code = 1'b1;
        tail.last = 1'b1;
        rect_q.push_back(tail);
        n_bad++;
        return;
      end
      draw_glyph(req.origin_x, req.origin_y, req.color, req.value[4:0]);
    end else begin
      n_hex++;
      cnt = int'(req.digit_count);
      if (cnt == 0) cnt = 1;
      if (cnt > MAXD) cnt = MAXD;
      gx = req.origin_x;
      for (int i = cnt; i > 0; i--) begin
        draw_glyph(gx, req.origin_y, req.color, {1'b0, req.value[(i-1)*4 +: 4]});
        gx = gx + 8'(PITCH);
      end
      draw_glyph(gx, req.origin_y, req.color, hexseg_pkg::GLYPH_H);
    end
    tail = rect_q.pop_back();
    tail.last = 1'b1;
    rect_q.push_back(tail);
  endtask

  task automatic compare_field(input string name, input logic [15:0] exp, input logic [15:0] act);
    if (act !== exp) begin
      errors++;
      $display("%0t ns: rect %0d field %s expected 0x%0h got 0x%0h", $time, n_rects, name,
               exp, act);
    end
  endtask

  task automatic check_rect(input hexseg_pkg::out_item_t got);
    hexseg_pkg::out_item_t want;
    if (rect_q.size() == 0) begin
      errors++;
      $display("%0t ns: rectangle with none expected, expected nothing got 0x%0h", $time, got);
      return;
    end
    want = rect_q.pop_front();
    compare_field("rect_x", 16'(want.rect_x), 16'(got.rect_x));
    compare_field("rect_y", 16'(want.rect_y), 16'(got.rect_y));
    compare_field("rect_w", 16'(want.rect_w), 16'(got.rect_w));
    compare_field("rect_h", 16'(want.rect_h), 16'(got.rect_h));
    compare_field("rect_color", want.rect_color, got.rect_color);
    compare_field("bad_code", 16'(want.bad_code), 16'(got.bad_code));
    compare_field("last", 16'(want.last), 16'(got.last));
    n_rects++;
  endtask

  // request/result monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles = idle_cycles + 1;
      if (push && !full) begin
        idle_cycles = 0;
        n_requests++;
        if (want_typed) begin
          rect_q.push_back(want_rect);
          n_bad++;
        end else begin
          predict_rects(in_item);
        end
      end
      if (pop && !empty) begin
        idle_cycles = 0;
        check_rect(out_item);
        stall_left = pick_gap();
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("hex_seven_segment_rect_generator_tb: done, errors");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic hexseg_pkg::in_item_t make_req(input logic op, input logic [7:0] x,
                                                    input logic [7:0] y,
                                                    input logic [15:0] col,
                                                    input logic [31:0] val,
                                                    input logic [3:0] cnt);
    hexseg_pkg::in_item_t r;
    r.op = op;
    r.origin_x = x;
    r.origin_y = y;
    r.color = col;
    r.value = val;
    r.digit_count = cnt;
    return r;
  endfunction

  task automatic add_row(input hexseg_pkg::in_item_t req, input bit typed,
                         input hexseg_pkg::out_item_t want);
    stim_row_t row;
    row.req = req;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  function automatic hexseg_pkg::in_item_t random_req();
    hexseg_pkg::in_item_t r;
    int pick;
    r.op = ($urandom_range(0, 99) < 60) ? hexseg_pkg::OP_HEX : hexseg_pkg::OP_GLYPH;
    r.origin_x = 8'($urandom);
    r.origin_y = 8'($urandom);
    if ($urandom_range(0, 9) == 0) r.origin_x = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    if ($urandom_range(0, 9) == 0) r.origin_y = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    r.color = 16'($urandom);
    r.value = $urandom;
    r.digit_count = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(1, MAXD));
    if (r.op == hexseg_pkg::OP_GLYPH) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) r.value = 32'($urandom_range(0, 16));
      else if (pick < 93) r.value = 32'($urandom_range(17, 63));
      else if (r.value <= TOP_CODE) r.value = r.value | 32'h8000_0000;
    end
    return r;
  endfunction

  task automatic send_request(input hexseg_pkg::in_item_t req, input bit typed,
                              input hexseg_pkg::out_item_t want);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_item <= req;
    want_typed <= typed;
    want_rect <= want;
    do @(posedge clk); while (full);
  endtask

  initial begin
    hexseg_pkg::out_item_t bad_rect;
    hexseg_pkg::out_item_t none;
    none = '0;
    bad_rect = '0;
    bad_rect.bad_code = 1'b1;
    bad_rect.last = 1'b1;

    // every glyph code once, spread over the screen
    for (int c = 0; c <= 16; c++)
      add_row(make_req(hexseg_pkg::OP_GLYPH, 8'(c * 15), 8'(c * 13), 16'(c * 4000 + 1),
                       32'(c), 4'(c)), 1'b0, none);
    add_row(make_req(hexseg_pkg::OP_GLYPH, 8'hFF, 8'hFF, 16'hFFFF, 32'd8, 4'hF), 1'b0, none);
    // bad glyph codes, including one whose low five bits look valid
    add_row(make_req(hexseg_pkg::OP_GLYPH, 8'h10, 8'h20, 16'h1234, 32'd17, 4'd1),
            1'b1, bad_rect);
    add_row(make_req(hexseg_pkg::OP_GLYPH, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 4'hF),
            1'b1, bad_rect);
    add_row(make_req(hexseg_pkg::OP_GLYPH, 8'h00, 8'h00, 16'h0000, 32'd32, 4'd0),
            1'b1, bad_rect);
    // hex mode: zero count, clamped count, column wrap, all-ones
    add_row(make_req(hexseg_pkg::OP_HEX, 8'd40, 8'd60, 16'hF800, 32'h0000_0008, 4'd0),
            1'b0, none);
    add_row(make_req(hexseg_pkg::OP_HEX, 8'd0, 8'd0, 16'h07E0, 32'h0123_4567, 4'd8),
            1'b0, none);
    add_row(make_req(hexseg_pkg::OP_HEX, 8'd250, 8'd100, 16'h001F, 32'hFEDC_BA98, 4'd15),
            1'b0, none);
    add_row(make_req(hexseg_pkg::OP_HEX, 8'hFF, 8'hFF, 16'h0000, 32'hFFFF_FFFF, 4'd9),
            1'b0, none);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      send_request(random_req(), 1'b0, none);
    end
    calm = 1'b0;

    @(negedge clk);
    push <= 1'b0;
    wait (rect_q.size() == 0);
    repeat (24) @(posedge clk);
    if (rect_q.size() != 0) begin
      errors++;
      $display("%0t ns: %0d rectangles never arrived", $time, rect_q.size());
    end

    $display("run: %0d requests (%0d hex strings, %0d bad glyph codes), %0d rectangles checked",
             n_requests, n_hex, n_bad, n_rects);
    if (errors == 0)
      $display("hex_seven_segment_rect_generator_tb: done, clean");
    else
      $display("hex_seven_segment_rect_generator_tb: done, errors");
    $finish;
  end

endmodule

>>> files.f
src/hexseg_pkg.sv
src/hexseg_front.sv
src/hexseg_queue.sv
src/hexseg_back.sv
src/hex_seven_segment_rect_generator.sv
sim/hex_seven_segment_rect_generator_tb.sv
